// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the circle point generator rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at each rising clock edge outside reset
`define CPG_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("cpg assertion failed");

// condition that must never be seen outside reset
`define CPG_ASSERT_NEVER(label, cond) \
  `CPG_ASSERT(label, !(cond))

`endif

// ===== rtl/core/cpg_pkg.sv =====
// shared types and constants for the circle point generator
// no dependencies
package cpg_pkg;

  localparam int unsigned COORD_W = 10;
  localparam int unsigned PIX_W   = COORD_W + 2;
  localparam int unsigned DEC_W   = COORD_W + 4;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QAW     = $clog2(QDEPTH);
  localparam int unsigned PIX_PER_STEP = 8;
  localparam int unsigned CNT_W   = $clog2(PIX_PER_STEP);

  // item kind codes
  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  // one input beat
  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] radius;
  } item_t;

  // one result beat
  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic                    last_of_run;
    logic                    done_res;
  } pixel_t;

  // one octant step handed from front to back
  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               done;
  } step_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/core/cpg_front.sv =====
// front end: accepts items, keeps the octant state, computes each step
// depends on cpg_pkg and assert_macros.svh
`include "assert_macros.svh"
module cpg_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cpg_pkg::item_t   item_i,
  input  cpg_pkg::q_status_t q_stat_i,
  output logic             wr_o,
  output cpg_pkg::step_t   step_o
);
  import cpg_pkg::*;

  logic [COORD_W-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [COORD_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [DEC_W-1:0] dec_q, dec_d;
  logic active_q, active_d;

  logic accept;
  logic is_start;
  logic emit;
  logic [COORD_W-1:0] cur_cx, cur_cy, cur_x, cur_y;
  logic signed [DEC_W-1:0] cur_dec, dec_new;
  logic signed [DEC_W-1:0] x_ext, y_ext;
  logic signed [PIX_W-1:0] nx_s, ny_s;
  logic done;

  assign accept   = push_i && !q_stat_i.full;
  assign is_start = (item_i.kind == KIND_START);
  assign emit     = accept && (is_start || active_q);

  // operands of this step: fresh circle or stored state
  always_comb begin
    if (is_start) begin
      cur_cx  = item_i.center_x;
      cur_cy  = item_i.center_y;
      cur_x   = '0;
      cur_y   = item_i.radius;
      cur_dec = DEC_W'(signed'(3)) - (signed'({{(DEC_W-COORD_W){1'b0}}, item_i.radius}) <<< 1);
    end else begin
      cur_cx  = cx_q;
      cur_cy  = cy_q;
      cur_x   = x_q;
      cur_y   = y_q;
      cur_dec = dec_q;
    end
  end

  // midpoint decision update with x before its increment
  always_comb begin
    x_ext = signed'({{(DEC_W-COORD_W){1'b0}}, cur_x});
    y_ext = signed'({{(DEC_W-COORD_W){1'b0}}, cur_y});
    nx_s  = signed'({2'b00, cur_x}) + PIX_W'(signed'(1));
    if (cur_dec < 0) begin
      dec_new = cur_dec + (x_ext <<< 2) + DEC_W'(signed'(6));
      ny_s    = signed'({2'b00, cur_y});
    end else begin
      dec_new = cur_dec + ((x_ext - y_ext) <<< 2) + DEC_W'(signed'(10));
      ny_s    = signed'({2'b00, cur_y}) - PIX_W'(signed'(1));
    end
    done = (nx_s > ny_s);
  end

  // next state
  always_comb begin
    cx_d     = cx_q;
    cy_d     = cy_q;
    x_d      = x_q;
    y_d      = y_q;
    dec_d    = dec_q;
    active_d = active_q;
    if (emit) begin
      cx_d  = cur_cx;
      cy_d  = cur_cy;
      dec_d = dec_new;
      if (done) begin
        active_d = 1'b0;
        x_d      = '0;
        y_d      = '0;
      end else begin
        active_d = 1'b1;
        x_d      = nx_s[COORD_W-1:0];
        y_d      = ny_s[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      x_q      <= '0;
      y_q      <= '0;
      dec_q    <= '0;
      active_q <= 1'b0;
    end else begin
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      x_q      <= x_d;
      y_q      <= y_d;
      dec_q    <= dec_d;
      active_q <= active_d;
    end
  end

  // step record for the back end
  assign wr_o        = emit;
  assign step_o.cx   = cur_cx;
  assign step_o.cy   = cur_cy;
  assign step_o.x    = cur_x;
  assign step_o.y    = cur_y;
  assign step_o.done = done;

  `CPG_ASSERT(a_done_ends_circle, (wr_o && step_o.done) |=> !active_q)
  `CPG_ASSERT(a_start_goes_out, (accept && is_start) |-> wr_o)

endmodule

// ===== rtl/core/cpg_step_fifo.sv =====
// short queue of step records between front and back
// depends on cpg_pkg and assert_macros.svh
`include "assert_macros.svh"
module cpg_step_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  cpg_pkg::step_t     wdata_i,
  input  logic               rd_i,
  output cpg_pkg::step_t     rdata_o,
  output cpg_pkg::q_status_t stat_o
);
  import cpg_pkg::*;

  step_t mem_q [QDEPTH];
  logic [QAW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QAW:0]   cnt_q, cnt_d;
  logic do_wr, do_rd;

  assign stat_o.full  = (cnt_q == (QAW+1)'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_wr = wr_i && !stat_o.full;
  assign do_rd = rd_i && !stat_o.empty;

  // pointer and fill count
  always_comb begin
    wptr_d = do_wr ? wptr_q + QAW'(1) : wptr_q;
    rptr_d = do_rd ? rptr_q + QAW'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + (QAW+1)'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rptr_q];

  `CPG_ASSERT_NEVER(a_no_write_when_full, wr_i && stat_o.full)
  `CPG_ASSERT_NEVER(a_no_read_when_empty, rd_i && stat_o.empty)

endmodule

// ===== rtl/core/cpg_back.sv =====
// back end: expands each step record into eight pixels, one per cycle unless a stalled receiver holds the output
// depends on cpg_pkg and assert_macros.svh
`include "assert_macros.svh"
module cpg_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cpg_pkg::step_t     step_i,
  input  cpg_pkg::q_status_t q_stat_i,
  output logic               rd_o,
  output cpg_pkg::pixel_t    pixel_o,
  output logic               empty_o,
  input  logic               pop_i
);
  import cpg_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic   out_valid_q, out_valid_d;
  pixel_t out_q, out_d;
  logic   load;
  logic [COORD_W-1:0] a_sel, b_sel;
  logic signed [PIX_W-1:0] cx_s, cy_s, a_s, b_s;

  assign load = !q_stat_i.empty && (!out_valid_q || pop_i);
  assign rd_o = load && (cnt_q == CNT_W'(PIX_PER_STEP - 1));

  // symmetric pixel for the current index
  always_comb begin
    a_sel = cnt_q[CNT_W-1] ? step_i.y : step_i.x;
    b_sel = cnt_q[CNT_W-1] ? step_i.x : step_i.y;
    cx_s  = signed'({2'b00, step_i.cx});
    cy_s  = signed'({2'b00, step_i.cy});
    a_s   = signed'({2'b00, a_sel});
    b_s   = signed'({2'b00, b_sel});
    out_d.pixel_x     = cnt_q[1] ? cx_s - a_s : cx_s + a_s;
    out_d.pixel_y     = cnt_q[0] ? cy_s - b_s : cy_s + b_s;
    out_d.last_of_run = (cnt_q == CNT_W'(PIX_PER_STEP - 1));
    out_d.done_res    = step_i.done;
  end

  // pixel index and output valid
  always_comb begin
    cnt_d       = load ? cnt_q + CNT_W'(1) : cnt_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign pixel_o = out_q;
  assign empty_o = !out_valid_q;

  `CPG_ASSERT(a_held_when_stalled, (out_valid_q && !pop_i) |=> (out_valid_q && $stable(out_q)))
  `CPG_ASSERT(a_last_frees_record, (load && out_d.last_of_run) |-> rd_o)

endmodule

// ===== rtl/core/circle_point_generator_top.sv =====
// top level of the midpoint circle pixel generator
// depends on cpg_pkg, cpg_front, cpg_step_fifo, cpg_back
//
// Input channel is a queue write side: drive item_i and raise push; the beat
// is taken at a rising edge with push high and full low. A start beat (kind 0)
// loads center and radius and yields the first octant step; an advance beat
// (kind 1) yields the next step, or nothing once the circle is finished.
// Each step gives eight pixel beats on the result side, a queue read side:
// pixel_o is valid while empty is low and is taken at an edge with pop high.
// The eighth pixel of a step has last_of_run set; every pixel of the final
// step has done_res set. A taken item's step is written into the step queue
// and then into the output register, from which pixel_o is driven.
// Throughput: one pixel per cycle at the output register while pop is high;
// the front takes an item per cycle until the four-entry step queue sets full.
// A stalled receiver holds the current pixel; the queue then fills and full
// rises. Reset clears the octant state, the queue and the output register
// valid; no circle is active after reset.
module circle_point_generator_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  cpg_pkg::item_t  item_i,
  output logic            empty,
  input  logic            pop,
  output cpg_pkg::pixel_t pixel_o
);
  import cpg_pkg::*;

  q_status_t q_stat;
  step_t     wr_step, rd_step;
  logic      q_wr, q_rd;

  cpg_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (item_i),
    .q_stat_i (q_stat),
    .wr_o     (q_wr),
    .step_o   (wr_step)
  );

  cpg_step_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (wr_step),
    .rd_i    (q_rd),
    .rdata_o (rd_step),
    .stat_o  (q_stat)
  );

  cpg_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (rd_step),
    .q_stat_i (q_stat),
    .rd_o     (q_rd),
    .pixel_o  (pixel_o),
    .empty_o  (empty),
    .pop_i    (pop)
  );

  assign full = q_stat.full;

endmodule
